// ===== hdl/svpm_pkg.sv =====
// Shared types, constants and tables for the SVPWM seven-segment modulator.
// No dependencies; imported by the core, svpm_front, svpm_times and svpm_duty.
package svpm_pkg;

   localparam int PERIOD_WIDTH_DEF = 16;
   localparam int QBITS            = 18;
   localparam int RATIO_BITS       = 20;
   localparam int SQ3H             = 14189;

   localparam logic [15:0] PERIOD_RST  = 16'd9000;
   localparam logic [14:0] MARGIN_RST  = 15'd270;

   localparam logic [1:0] CSR_PERIOD  = 2'd0;
   localparam logic [1:0] CSR_MARGIN  = 2'd1;
   localparam logic [1:0] CSR_REVERSE = 2'd2;

   typedef struct packed {
      logic signed [11:0] a;
      logic signed [11:0] b;
      logic signed [11:0] c;
   } dt_type;

   typedef enum logic [1:0] {
      OM_NONE,
      OM_CLIP1,
      OM_CLIP2,
      OM_SCALE
   } om_type;

   // phase slots of the three duty levels {third, second, first}
   function automatic logic [5:0] phase_map(input logic [2:0] sec);
      logic [5:0] m;
      case (sec)
         3'd1:    m = {2'd2, 2'd0, 2'd1};
         3'd2:    m = {2'd1, 2'd2, 2'd0};
         3'd4:    m = {2'd0, 2'd1, 2'd2};
         3'd5:    m = {2'd0, 2'd2, 2'd1};
         3'd6:    m = {2'd1, 2'd0, 2'd2};
         default: m = {2'd2, 2'd1, 2'd0};
      endcase
      return m;
   endfunction

endpackage

// ===== hdl/svpwm_seven_segment_modulator_core.sv =====
// Top level of the SVPWM seven-segment modulator: CSRs and the pipeline.
// Depends on svpm_pkg, svpm_front, svpm_times, svpm_duty.
//
// Use: one transfer on req_* carries d/q commands, rotor sine/cosine, bus
// voltages and three dead-time corrections; one transfer on rsp_* returns
// the three channel compares and the sector code.
// CSRs are written on csr_* (csr_ready is always high): index 0 period,
// 1 clamp margin, 2 phase reverse. Write them only while the pipe is empty.
// Throughput: one item per cycle while the pipe is not held by a stall.
// Each item passes through the front and its bus divider, the times stages
// and their overmodulation ratio divider, and the duty stages, in that order.
// Stall: the whole pipe holds while rsp_valid and rsp_stall are both high;
// req_stall is raised in exactly those cycles, nothing is lost or repeated.
// Reset: synchronous; empties the pipe and restores period 9000,
// margin 270, normal phase order.
module svpwm_seven_segment_modulator_core #(
   parameter int PERIOD_WIDTH = svpm_pkg::PERIOD_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_volt_d,
   input  logic signed [15:0] req_volt_q,
   input  logic signed [15:0] req_angle_cos,
   input  logic signed [15:0] req_angle_sin,
   input  logic [15:0]        req_bus_raw,
   input  logic [15:0]        req_bus_filtered,
   input  logic signed [11:0] req_deadtime_a,
   input  logic signed [11:0] req_deadtime_b,
   input  logic signed [11:0] req_deadtime_c,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_compare_ch1,
   output logic [15:0]        rsp_compare_ch2,
   output logic [15:0]        rsp_compare_ch3,
   output logic [2:0]         rsp_sector,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import svpm_pkg::*;

   localparam int PW  = PERIOD_WIDTH;
   localparam int PFW = (PW > 16) ? PW : 16;

   logic [15:0] period_ff;
   logic [14:0] margin_ff;
   logic        reverse_ff;
   logic [PFW-1:0] per_full;
   logic [PW-1:0]  per;
   logic           adv;

   assign csr_ready = 1'b1;
   assign per_full  = PFW'(period_ff);
   assign per       = per_full[PW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= PERIOD_RST;
         margin_ff  <= MARGIN_RST;
         reverse_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PERIOD:  period_ff  <= csr_wdata;
            CSR_MARGIN:  margin_ff  <= csr_wdata[14:0];
            CSR_REVERSE: reverse_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   dt_type                  dt_req, dt_f, dt_t;
   logic                    fv, tv;
   logic signed [PW+21:0]   va, vb;
   logic [2:0]              sec;
   logic signed [PW+37:0]   t1, t2;

   assign dt_req = '{a: req_deadtime_a, b: req_deadtime_b, c: req_deadtime_c};

   svpm_front #(.PW(PW)) u_front (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(req_valid),
      .volt_d(req_volt_d), .volt_q(req_volt_q),
      .angle_cos(req_angle_cos), .angle_sin(req_angle_sin),
      .bus_raw(req_bus_raw), .bus_filtered(req_bus_filtered),
      .dt_in(dt_req), .per(per),
      .out_valid(fv), .va(va), .vb(vb), .dt_out(dt_f)
   );

   svpm_times #(.PW(PW)) u_times (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(fv),
      .va(va), .vb(vb), .dt_in(dt_f), .per(per),
      .out_valid(tv), .sec(sec), .t1(t1), .t2(t2), .dt_out(dt_t)
   );

   svpm_duty #(.PW(PW)) u_duty (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(tv),
      .sec(sec), .t1(t1), .t2(t2), .dt_in(dt_t),
      .per(per), .mar(margin_ff), .rev(reverse_ff),
      .out_valid(rsp_valid),
      .compare_ch1(rsp_compare_ch1), .compare_ch2(rsp_compare_ch2),
      .compare_ch3(rsp_compare_ch3), .sector(rsp_sector)
   );

endmodule

// ===== hdl/svpm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on nothing; used by svpm_front and svpm_times.
module svpm_div #(
   parameter int NUM_W  = 20,
   parameter int DEN_W  = 16,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  rem0,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  quo,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [NUM_W];
   logic [NUM_W-1:0]  num_ff   [NUM_W];
   logic [NUM_W-1:0]  quo_ff   [NUM_W];
   logic [DEN_W-1:0]  rem_ff   [NUM_W];
   logic [DEN_W-1:0]  den_ff   [NUM_W];
   logic [SIDE_W-1:0] side_ff  [NUM_W];

   for (genvar g = 0; g < NUM_W; g++) begin : g_stage
      logic              v_src;
      logic [NUM_W-1:0]  n_src;
      logic [NUM_W-1:0]  q_src;
      logic [DEN_W-1:0]  r_src;
      logic [DEN_W-1:0]  d_src;
      logic [SIDE_W-1:0] s_src;
      logic [DEN_W:0]    trial;
      logic              take;
      logic [DEN_W-1:0]  rem_in;

      if (g == 0) begin : g_first
         assign v_src = in_valid;
         assign n_src = num;
         assign q_src = '0;
         assign r_src = rem0;
         assign d_src = den;
         assign s_src = side;
      end else begin : g_next
         assign v_src = valid_ff[g-1];
         assign n_src = num_ff[g-1];
         assign q_src = quo_ff[g-1];
         assign r_src = rem_ff[g-1];
         assign d_src = den_ff[g-1];
         assign s_src = side_ff[g-1];
      end

      assign trial  = {r_src, n_src[NUM_W-1]};
      assign take   = trial >= {1'b0, d_src};
      assign rem_in = take ? DEN_W'(trial - {1'b0, d_src}) : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (adv) begin
            valid_ff[g] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            num_ff[g]  <= n_src << 1;
            quo_ff[g]  <= {q_src[NUM_W-2:0], take};
            rem_ff[g]  <= rem_in;
            den_ff[g]  <= d_src;
            side_ff[g] <= s_src;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign quo       = quo_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

// ===== hdl/svpm_front.sv =====
// Scaling and inverse Park: products, magnitudes, period scaling, bus divide.
// Depends on svpm_pkg and svpm_div.
module svpm_front #(
   parameter int PW = svpm_pkg::PERIOD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic signed [15:0]     volt_d,
   input  logic signed [15:0]     volt_q,
   input  logic signed [15:0]     angle_cos,
   input  logic signed [15:0]     angle_sin,
   input  logic [15:0]            bus_raw,
   input  logic [15:0]            bus_filtered,
   input  svpm_pkg::dt_type       dt_in,
   input  logic [PW-1:0]          per,
   output logic                   out_valid,
   output logic signed [PW+21:0]  va,
   output logic signed [PW+21:0]  vb,
   output svpm_pkg::dt_type       dt_out
);
   import svpm_pkg::*;

   localparam int MPW = 32 + PW;
   localparam int QW  = MPW - 11;
   localparam int VW  = QW + 1;

   typedef struct packed {
      logic   neg;
      dt_type dt;
   } aside_type;

   // stage 1
   logic               v1_ff;
   logic signed [31:0] pdc_ff, pqs_ff, pds_ff, pqc_ff;
   logic signed [31:0] pdc_in, pqs_in, pds_in, pqc_in;
   logic [15:0]        bus1_ff, bus1_in;
   dt_type             dt1_ff;

   assign pdc_in  = volt_d * angle_cos;
   assign pqs_in  = volt_q * angle_sin;
   assign pds_in  = volt_d * angle_sin;
   assign pqc_in  = volt_q * angle_cos;
   assign bus1_in = (bus_raw == 16'd0 || bus_filtered == 16'd0) ? 16'd1 : bus_filtered;

   // stage 2
   logic               v2_ff;
   logic signed [32:0] sa, sb, na, nb;
   logic [31:0]        ma2_ff, mb2_ff, ma2_in, mb2_in;
   logic               nega2_ff, negb2_ff;
   logic [15:0]        bus2_ff;
   dt_type             dt2_ff;

   assign sa     = 33'(pdc_ff) - 33'(pqs_ff);
   assign sb     = 33'(pds_ff) + 33'(pqc_ff);
   assign na     = -sa;
   assign nb     = -sb;
   assign ma2_in = sa[32] ? na[31:0] : sa[31:0];
   assign mb2_in = sb[32] ? nb[31:0] : sb[31:0];

   // stage 3
   logic              v3_ff;
   logic [MPW-1:0]    pa, pb;
   logic [QW-1:0]     qa3_ff, qb3_ff;
   logic              nega3_ff, negb3_ff;
   logic [15:0]       bus3_ff;
   dt_type            dt3_ff;

   assign pa = MPW'(ma2_ff) * MPW'(per);
   assign pb = MPW'(mb2_ff) * MPW'(per);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pdc_ff   <= pdc_in;
         pqs_ff   <= pqs_in;
         pds_ff   <= pds_in;
         pqc_ff   <= pqc_in;
         bus1_ff  <= bus1_in;
         dt1_ff   <= dt_in;
         ma2_ff   <= ma2_in;
         mb2_ff   <= mb2_in;
         nega2_ff <= sa[32];
         negb2_ff <= sb[32];
         bus2_ff  <= bus1_ff;
         dt2_ff   <= dt1_ff;
         qa3_ff   <= pa[MPW-1:11];
         qb3_ff   <= pb[MPW-1:11];
         nega3_ff <= nega2_ff;
         negb3_ff <= negb2_ff;
         bus3_ff  <= bus2_ff;
         dt3_ff   <= dt2_ff;
      end
   end

   // bus divide
   logic              dva;
   logic [QW-1:0]     qa, qb;
   logic [$bits(aside_type)-1:0] aside_o;
   logic              negb_o;
   aside_type         aside_s;

   svpm_div #(.NUM_W(QW), .DEN_W(16), .SIDE_W($bits(aside_type))) u_div_a (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(v3_ff),
      .num(qa3_ff), .rem0(16'd0), .den(bus3_ff),
      .side({nega3_ff, dt3_ff}),
      .out_valid(dva), .quo(qa), .out_side(aside_o)
   );

   svpm_div #(.NUM_W(QW), .DEN_W(16), .SIDE_W(1)) u_div_b (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(v3_ff),
      .num(qb3_ff), .rem0(16'd0), .den(bus3_ff),
      .side(negb3_ff),
      .out_valid(), .quo(qb), .out_side(negb_o)
   );

   assign aside_s = aside_type'(aside_o);

   // signed result
   logic              vo_ff;
   logic signed [VW-1:0] va_ff, vb_ff, va_in, vb_in;
   dt_type            dto_ff;

   assign va_in = aside_s.neg ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
   assign vb_in = negb_o ? -$signed({1'b0, qb}) : $signed({1'b0, qb});

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= dva;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         va_ff  <= va_in;
         vb_ff  <= vb_in;
         dto_ff <= aside_s.dt;
      end
   end

   assign out_valid = vo_ff;
   assign va        = va_ff;
   assign vb        = vb_ff;
   assign dt_out    = dto_ff;

endmodule

// ===== hdl/svpm_times.sv =====
// Sector search, active vector times and overmodulation limiting.
// Depends on svpm_pkg and svpm_div.
module svpm_times #(
   parameter int PW = svpm_pkg::PERIOD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic signed [PW+21:0]  va,
   input  logic signed [PW+21:0]  vb,
   input  svpm_pkg::dt_type       dt_in,
   input  logic [PW-1:0]          per,
   output logic                   out_valid,
   output logic [2:0]             sec,
   output logic signed [PW+37:0]  t1,
   output logic signed [PW+37:0]  t2,
   output svpm_pkg::dt_type       dt_out
);
   import svpm_pkg::*;

   localparam int XW = 37 + PW;
   localparam int TW = XW + 1;
   localparam int SW = TW + 1;
   localparam int UW = PW + QBITS;

   typedef struct packed {
      om_type                mode;
      logic [2:0]            sec;
      logic signed [TW-1:0]  t1;
      logic signed [TW-1:0]  t2;
      dt_type                dt;
   } tside_type;

   logic signed [TW-1:0] p;
   assign p = signed'(TW'({per, {QBITS{1'b0}}}));

   // stage 1: X, Y, Z
   logic                 v1_ff;
   logic signed [XW-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in, m, b13;
   dt_type               dt1_ff;

   assign m    = XW'(va) * SQ3H;
   assign b13  = XW'(vb) <<< 13;
   assign x_in = XW'(vb) <<< 14;
   assign y_in = b13 + m;
   assign z_in = b13 - m;

   // stage 2: sector and times
   logic                 v2_ff;
   logic [2:0]           sec_in, sec2_ff;
   logic signed [TW-1:0] xe, ye, ze, ta_in, tb_in, ta2_ff, tb2_ff;
   dt_type               dt2_ff;

   assign xe = TW'(x_ff);
   assign ye = TW'(y_ff);
   assign ze = TW'(z_ff);
   assign sec_in = {y_ff < 0, z_ff < 0, x_ff > 0};

   always_comb begin
      case (sec_in)
         3'd1:    begin ta_in = ze;  tb_in = ye;  end
         3'd2:    begin ta_in = ye;  tb_in = -xe; end
         3'd3:    begin ta_in = -ze; tb_in = xe;  end
         3'd4:    begin ta_in = -xe; tb_in = ze;  end
         3'd5:    begin ta_in = xe;  tb_in = -ye; end
         3'd6:    begin ta_in = -ye; tb_in = -ze; end
         default: begin ta_in = '0;  tb_in = '0;  end
      endcase
   end

   // stage 3: limit decision
   logic                 v3_ff;
   logic signed [SW-1:0] s;
   om_type               mode_in;
   tside_type            side3_ff;
   logic [SW-1:0]        s3_ff;

   assign s = SW'(ta2_ff) + SW'(tb2_ff);

   always_comb begin
      if (s <= SW'(p)) begin
         mode_in = OM_NONE;
      end else if (ta2_ff > p && ta2_ff >= tb2_ff) begin
         mode_in = OM_CLIP1;
      end else if (tb2_ff > p && tb2_ff >= ta2_ff) begin
         mode_in = OM_CLIP2;
      end else begin
         mode_in = OM_SCALE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff          <= x_in;
         y_ff          <= y_in;
         z_ff          <= z_in;
         dt1_ff        <= dt_in;
         sec2_ff       <= sec_in;
         ta2_ff        <= ta_in;
         tb2_ff        <= tb_in;
         dt2_ff        <= dt1_ff;
         side3_ff.mode <= mode_in;
         side3_ff.sec  <= sec2_ff;
         side3_ff.t1   <= ta2_ff;
         side3_ff.t2   <= tb2_ff;
         side3_ff.dt   <= dt2_ff;
         s3_ff         <= s;
      end
   end

   // ratio P * 2^20 / (t1 + t2)
   logic                          dv;
   logic [RATIO_BITS-1:0]         r;
   logic [$bits(tside_type)-1:0]  side_o;
   tside_type                     sd;

   svpm_div #(.NUM_W(RATIO_BITS), .DEN_W(SW), .SIDE_W($bits(tside_type))) u_div (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(v3_ff),
      .num('0), .rem0(SW'(p)), .den(s3_ff), .side(side3_ff),
      .out_valid(dv), .quo(r), .out_side(side_o)
   );

   assign sd = tside_type'(side_o);

   // final times
   logic [UW+RATIO_BITS-1:0] m1, m2;
   logic signed [TW-1:0]     t1_in, t2_in, t1_ff, t2_ff;
   logic                     vo_ff;
   logic [2:0]               seco_ff;
   dt_type                   dto_ff;

   assign m1 = (UW + RATIO_BITS)'(sd.t1[UW-1:0]) * (UW + RATIO_BITS)'(r);
   assign m2 = (UW + RATIO_BITS)'(sd.t2[UW-1:0]) * (UW + RATIO_BITS)'(r);

   always_comb begin
      case (sd.mode)
         OM_CLIP1: begin t1_in = p;  t2_in = '0; end
         OM_CLIP2: begin t1_in = '0; t2_in = p;  end
         OM_SCALE: begin
            t1_in = signed'(TW'(m1[UW+RATIO_BITS-1:RATIO_BITS]));
            t2_in = signed'(TW'(m2[UW+RATIO_BITS-1:RATIO_BITS]));
         end
         default:  begin t1_in = sd.t1; t2_in = sd.t2; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= dv;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff   <= t1_in;
         t2_ff   <= t2_in;
         seco_ff <= sd.sec;
         dto_ff  <= sd.dt;
      end
   end

   assign out_valid = vo_ff;
   assign sec       = seco_ff;
   assign t1        = t1_ff;
   assign t2        = t2_ff;
   assign dt_out    = dto_ff;

endmodule

// ===== hdl/svpm_duty.sv =====
// Duty levels, dead-time correction, rail clamp and compare output register.
// Depends on svpm_pkg.
module svpm_duty #(
   parameter int PW = svpm_pkg::PERIOD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic [2:0]             sec,
   input  logic signed [PW+37:0]  t1,
   input  logic signed [PW+37:0]  t2,
   input  svpm_pkg::dt_type       dt_in,
   input  logic [PW-1:0]          per,
   input  logic [14:0]            mar,
   input  logic                   rev,
   output logic                   out_valid,
   output logic [15:0]            compare_ch1,
   output logic [15:0]            compare_ch2,
   output logic [15:0]            compare_ch3,
   output logic [2:0]             sector
);
   import svpm_pkg::*;

   localparam int DW = PW + 40;
   localparam int CW = DW + 1;

   logic signed [DW-1:0] p;
   assign p = signed'(DW'({per, {QBITS{1'b0}}}));

   // stage 1: first duty
   logic                 v1_ff;
   logic signed [DW-1:0] h_in, h_ff, t1_ff, t2_ff;
   logic [2:0]           sec1_ff;
   dt_type               dt1_ff;

   assign h_in = (p - DW'(t1) - DW'(t2)) >>> 1;

   // stage 2: levels to phases plus dead time
   logic                 v2_ff;
   logic signed [DW-1:0] lvl [3];
   logic signed [DW-1:0] dmid [3];
   logic signed [DW-1:0] dts [3];
   logic signed [DW-1:0] d2_ff [3];
   logic [5:0]           pm;
   logic [2:0]           sec2_ff;

   assign lvl[0] = h_ff;
   assign lvl[1] = h_ff + t1_ff;
   assign lvl[2] = h_ff + t1_ff + t2_ff;
   assign pm     = phase_map(sec1_ff);
   assign dts[0] = DW'(dt1_ff.a) <<< QBITS;
   assign dts[1] = DW'(dt1_ff.b) <<< QBITS;
   assign dts[2] = DW'(dt1_ff.c) <<< QBITS;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dmid[k] = '0;
      end
      if (sec1_ff == 3'd0) begin
         for (int k = 0; k < 3; k++) begin
            dmid[k] = signed'(DW'({per, {(QBITS-1){1'b0}}}));
         end
      end else begin
         for (int k = 0; k < 3; k++) begin
            dmid[pm[2*k +: 2]] = lvl[k];
         end
      end
   end

   // stage 3: rail clamp
   logic                 v3_ff;
   logic signed [DW-1:0] hi, lo, rail_hi, rail_lo;
   logic signed [DW-1:0] d3_in [3];
   logic signed [DW-1:0] d3_ff [3];
   logic [2:0]           sec3_ff;

   assign hi      = (signed'(DW'(per)) - signed'(DW'(mar))) <<< QBITS;
   assign lo      = signed'(DW'(mar)) <<< QBITS;
   assign rail_hi = (signed'(DW'(per)) - DW'(1)) <<< QBITS;
   assign rail_lo = DW'(1) <<< QBITS;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (d2_ff[k] > hi) begin
            d3_in[k] = rail_hi;
         end else if (d2_ff[k] < lo) begin
            d3_in[k] = rail_lo;
         end else begin
            d3_in[k] = d2_ff[k];
         end
      end
   end

   // stage 4: compares
   logic signed [CW-1:0] c [3];
   logic [15:0]          cmp [3];
   logic                 vo_ff;
   logic [15:0]          c1_ff, c2_ff, c3_ff;
   logic [2:0]           seco_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         c[k] = CW'(p) - CW'(d3_ff[k]);
         if (c[k] < 0) begin
            cmp[k] = 16'd0;
         end else if ((c[k] >>> QBITS) > CW'(16'hFFFF)) begin
            cmp[k] = 16'hFFFF;
         end else begin
            cmp[k] = c[k][QBITS +: 16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vo_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_ff    <= h_in;
         t1_ff   <= DW'(t1);
         t2_ff   <= DW'(t2);
         sec1_ff <= sec;
         dt1_ff  <= dt_in;
         for (int k = 0; k < 3; k++) begin
            d2_ff[k] <= dmid[k] + dts[k];
            d3_ff[k] <= d3_in[k];
         end
         sec2_ff <= sec1_ff;
         sec3_ff <= sec2_ff;
         seco_ff <= sec3_ff;
         c1_ff   <= cmp[0];
         c2_ff   <= rev ? cmp[2] : cmp[1];
         c3_ff   <= rev ? cmp[1] : cmp[2];
      end
   end

   assign out_valid   = vo_ff;
   assign compare_ch1 = c1_ff;
   assign compare_ch2 = c2_ff;
   assign compare_ch3 = c3_ff;
   assign sector      = seco_ff;

endmodule

// ===== hdl/svpm_checker.sv =====
// Port-level checks for the SVPWM modulator, bound to the top level.
// Depends only on the top level's ports.
module svpm_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [15:0]        rsp_compare_ch1,
   input logic [15:0]        rsp_compare_ch2,
   input logic [15:0]        rsp_compare_ch3,
   input logic [2:0]         rsp_sector
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_compare_ch1)
         && $stable(rsp_compare_ch2) && $stable(rsp_compare_ch3)
         && $stable(rsp_sector))
      else $error("stalled result changed");

   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sector != 3'd7)
      else $error("sector code out of range");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output stall");

endmodule

bind svpwm_seven_segment_modulator_core svpm_checker u_svpm_checker (.*);

// ===== dv/tb_svpwm_seven_segment_modulator_core.sv =====
// Self-checking testbench for svpwm_seven_segment_modulator_core.
// Predicts compares and sector per transfer, checks them in order under random idling and output stalls.
// Depends on svpm_pkg and the core RTL only.
module tb_svpwm_seven_segment_modulator_core;
   timeunit 1ns;
   timeprecision 1ps;
   import svpm_pkg::*;

   typedef struct {
      logic signed [15:0] vd, vq, cs, sn;
      logic [15:0]        braw, bfil;
      logic signed [11:0] da, db, dc;
   } cmd_t;

   typedef struct {
      logic [15:0] c1, c2, c3;
      logic [2:0]  sec;
   } cmp_t;

   class compare_scoreboard;
      longint unsigned period = 9000;
      longint          margin = 270;
      bit              reverse = 0;
      cmp_t            pending[$];
      int              mismatches = 0;

      function logic [15:0] rail_compare(longint p, longint duty);
         longint c;
         c = p - duty;
         if (c < 0) return 16'd0;
         c = c >>> 18;
         return (c > 65535) ? 16'hFFFF : c[15:0];
      endfunction

      function void note_command(cmd_t t);
         longint per, p, bus, va, vb, x, y, z, t1, t2, h, hi, lo, s, r, dt[3], duty[3];
         int unsigned sec;
         int o0, o1, o2;
         cmp_t e;
         per = longint'(period & 16'hFFFF);
         p = per * 262144;
         bus = (t.braw == 0 || t.bfil == 0) ? 1 : longint'(t.bfil);
         va = ((longint'(t.vd) * t.cs - longint'(t.vq) * t.sn) * per) / (bus * 2048);
         vb = ((longint'(t.vd) * t.sn + longint'(t.vq) * t.cs) * per) / (bus * 2048);
         x = vb * 16384;
         y = vb * 8192 + va * SQ3H;
         z = vb * 8192 - va * SQ3H;
         sec = 0;
         if (x > 0) sec |= 1;
         if (-z > 0) sec |= 2;
         if (-y > 0) sec |= 4;
         t1 = 0; t2 = 0;
         case (sec)
            1: begin t1 = z;  t2 = y;  end
            2: begin t1 = y;  t2 = -x; end
            3: begin t1 = -z; t2 = x;  end
            4: begin t1 = -x; t2 = z;  end
            5: begin t1 = x;  t2 = -y; end
            6: begin t1 = -y; t2 = -z; end
            default: sec = 0;
         endcase
         if (sec == 0) begin
            duty[0] = per * 131072; duty[1] = duty[0]; duty[2] = duty[0];
         end else begin
            s = t1 + t2;
            if (s > p) begin
               if (t1 > p && t1 >= t2) begin
                  t1 = p; t2 = 0;
               end else if (t2 > p && t2 >= t1) begin
                  t1 = 0; t2 = p;
               end else begin
                  r = (p * 1048576) / s;
                  t1 = (t1 * r) >>> 20;
                  t2 = (t2 * r) >>> 20;
               end
            end
            h = (p - t1 - t2) >>> 1;
            case (sec)
               1: begin o0 = 1; o1 = 0; o2 = 2; end
               2: begin o0 = 0; o1 = 2; o2 = 1; end
               4: begin o0 = 2; o1 = 1; o2 = 0; end
               5: begin o0 = 1; o1 = 2; o2 = 0; end
               6: begin o0 = 2; o1 = 0; o2 = 1; end
               default: begin o0 = 0; o1 = 1; o2 = 2; end
            endcase
            duty[o0] = h;
            duty[o1] = h + t1;
            duty[o2] = h + t1 + t2;
         end
         dt[0] = longint'(t.da); dt[1] = longint'(t.db); dt[2] = longint'(t.dc);
         hi = (per - margin) * 262144;
         lo = margin * 262144;
         for (int i = 0; i < 3; i++) begin
            duty[i] += dt[i] * 262144;
            if (duty[i] > hi) duty[i] = (per - 1) * 262144;
            else if (duty[i] < lo) duty[i] = 262144;
         end
         e.c1 = rail_compare(p, duty[0]);
         e.c2 = rail_compare(p, reverse ? duty[2] : duty[1]);
         e.c3 = rail_compare(p, reverse ? duty[1] : duty[2]);
         e.sec = sec[2:0];
         pending.push_back(e);
      endfunction

      function void check_result(cmp_t a);
         cmp_t e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result c1=%0d c2=%0d c3=%0d sec=%0d",
                                           a.c1, a.c2, a.c3, a.sec);
            return;
         end
         e = pending.pop_front();
         if (a.c1 !== e.c1 || a.c2 !== e.c2 || a.c3 !== e.c3 || a.sec !== e.sec) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp c1=%0d c2=%0d c3=%0d sec=%0d got c1=%0d c2=%0d c3=%0d sec=%0d",
                        e.c1, e.c2, e.c3, e.sec, a.c1, a.c2, a.c3, a.sec);
         end
      endfunction
   endclass

   logic               clock = 0, reset = 1;
   logic               req_valid = 0, req_stall;
   logic signed [15:0] req_volt_d = 0, req_volt_q = 0, req_angle_cos = 0, req_angle_sin = 0;
   logic [15:0]        req_bus_raw = 0, req_bus_filtered = 0;
   logic signed [11:0] req_deadtime_a = 0, req_deadtime_b = 0, req_deadtime_c = 0;
   logic               rsp_valid, rsp_stall = 0;
   logic [15:0]        rsp_compare_ch1, rsp_compare_ch2, rsp_compare_ch3;
   logic [2:0]         rsp_sector;
   logic               csr_valid = 0, csr_ready;
   logic [1:0]         csr_index = CSR_PERIOD;
   logic [15:0]        csr_wdata = 0;

   compare_scoreboard sb = new();
   bit idle_on = 1;
   int hold_cycles = 0;
   int stall_left = 0;

   svpwm_seven_segment_modulator_core dut (.*);

   initial forever #4 clock = ~clock;

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{rsp_compare_ch1, rsp_compare_ch2, rsp_compare_ch3, rsp_sector});
   end

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1;
         hold_cycles--;
      end else if (stall_left > 0) begin
         rsp_stall <= 1;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1;
         stall_left = $urandom_range(0, 7);
      end else begin
         rsp_stall <= 0;
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [15:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PERIOD:  sb.period = 64'(data);
         CSR_MARGIN:  sb.margin = 64'(data[14:0]);
         CSR_REVERSE: sb.reverse = data[0];
         default: ;
      endcase
   endtask

   task automatic drain_pipe();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic configure(logic [15:0] per, logic [14:0] mar, bit rev);
      drain_pipe();
      write_csr(CSR_PERIOD, per);
      write_csr(CSR_MARGIN, {1'b0, mar});
      write_csr(CSR_REVERSE, {15'd0, rev});
      csr_valid <= 0;
   endtask

   task automatic send_command(cmd_t t);
      req_valid <= 1;
      req_volt_d <= t.vd; req_volt_q <= t.vq;
      req_angle_cos <= t.cs; req_angle_sin <= t.sn;
      req_bus_raw <= t.braw; req_bus_filtered <= t.bfil;
      req_deadtime_a <= t.da; req_deadtime_b <= t.db; req_deadtime_c <= t.dc;
      do @(posedge clock); while (req_stall);
      sb.note_command(t);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic end_burst();
      req_valid <= 0;
      @(posedge clock);
   endtask

   function automatic cmd_t random_command();
      cmd_t t;
      int mode;
      mode = $urandom_range(0, 9);
      t.vd = 16'($urandom); t.vq = 16'($urandom); t.cs = 16'($urandom); t.sn = 16'($urandom);
      t.braw = 16'($urandom); t.bfil = 16'($urandom);
      if (mode < 6) begin
         t.bfil = 16'($urandom_range(2000, 65535));
         t.braw = t.bfil;
         t.vd = $signed(16'($urandom_range(0, 2 * t.bfil[15:1]))) - $signed({1'b0, t.bfil[15:1]});
         t.vq = $signed(16'($urandom_range(0, 2 * t.bfil[15:1]))) - $signed({1'b0, t.bfil[15:1]});
      end else if (mode == 6) begin
         t.braw = 0;
      end else if (mode == 7) begin
         t.bfil = 0;
         t.vd = $signed(16'($urandom_range(0, 15))) - 16'sd8;
      end
      if ($urandom_range(0, 3) == 0) begin
         t.da = 12'($urandom); t.db = 12'($urandom); t.dc = 12'($urandom);
      end else begin
         t.da = $signed(12'($urandom_range(0, 200))) - 12'sd100;
         t.db = $signed(12'($urandom_range(0, 200))) - 12'sd100;
         t.dc = $signed(12'($urandom_range(0, 200))) - 12'sd100;
      end
      return t;
   endfunction

   initial begin
      cmd_t t;
      cmd_t dir[$];
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // zero vector, extremes, each sector, zero bus, rails
      dir.push_back('{0, 0, 32767, 0, 6400, 6400, 0, 0, 0});
      dir.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
      dir.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF,
                      12'sh7FF, 12'sh7FF, 12'sh7FF});
      dir.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1, 1,
                      12'sh800, 12'sh800, 12'sh800});
      for (int k = 0; k < 6; k++) begin
         t = '{2000, 0, 0, 0, 6400, 6400, 0, 0, 0};
         t.cs = 16'($rtoi(32767.0 * $cos(3.14159265 * (2 * k + 1) / 6.0)));
         t.sn = 16'($rtoi(32767.0 * $sin(3.14159265 * (2 * k + 1) / 6.0)));
         dir.push_back(t);
         t.vd = 16'sh7FFF;
         dir.push_back(t);
      end
      dir.push_back('{100, 50, 32767, 0, 0, 6400, 0, 0, 0});
      dir.push_back('{100, 50, 32767, 0, 6400, 0, 0, 0, 0});
      dir.push_back('{3000, 1000, 20000, 20000, 6400, 6400, 12'sh7FF, 12'sh800, 5});
      dir.push_back('{-3000, 1000, 20000, -20000, 6400, 6400, -5, 0, 12'sh7FF});
      foreach (dir[k]) send_command(dir[k]);
      end_burst();

      configure(16'hFFFF, 15'd0, 1);
      foreach (dir[k]) send_command(dir[k]);
      end_burst();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: configure(16'd9000, 15'd270, 0);
            1: configure(16'd1, 15'h7FFF, 1);
            2: configure(16'hFFFF, 15'd0, 0);
            3: configure(16'($urandom_range(100, 20000)), 15'($urandom_range(0, 3000)), 1);
            4: configure(16'd500, 15'd300, 0);
            default: configure(16'd12000, 15'd100, 1);
         endcase
         idle_on = (ph != 5);
         if (ph == 2) hold_cycles = 300;
         for (int n = 0; n < 320; n++) send_command(random_command());
         end_burst();
      end

      drain_pipe();
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

// ===== filelist.f =====
hdl/svpm_pkg.sv
hdl/svpm_div.sv
hdl/svpm_front.sv
hdl/svpm_times.sv
hdl/svpm_duty.sv
hdl/svpwm_seven_segment_modulator_core.sv
hdl/svpm_checker.sv
dv/tb_svpwm_seven_segment_modulator_core.sv
